/* src/trp_pkg.sv */
// Shared types and constants for the transfer ring producer.
package trp_pkg;

  localparam int RING_MAX    = 256;
  localparam int MAX_REQ_LEN = 8;
  localparam int IDX_W       = $clog2(RING_MAX);
  localparam int LEN_W       = 4;
  localparam int TAG_W       = 8;
  localparam int ADDR_W      = 64;
  localparam int SLOTS_W     = 9;
  localparam int ENTRY_SHIFT = 4;   // 16-byte ring entries

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_COMPLETE = 1'b1
  } op_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NO_PEND = 2'd2;

  localparam logic [0:0] REG_RING_SLOTS = 1'b0;
  localparam logic [0:0] REG_RING_BASE  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TAG_W-1:0]  req_tag;
    logic [LEN_W-1:0]  req_len;
    logic [ADDR_W-1:0] entry_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       slot_index;
    logic             cycle_value;
    logic             is_link;
    logic [TAG_W-1:0] owner_tag;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } owner_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_INSERT,
    S_COMPLETE
  } state_t;

endpackage

/* src/transfer_ring_producer.sv */
// Transfer ring producer: slot allocation, cycle bit and owner tracking for a linked ring.
//
// Ring producer for a command/transfer ring whose last slot is a link entry.
// An insert transfer asks for req_len slots for request req_tag; if it fits in
// ring_slots-1 usable slots (and req_len is at most MAX_REQ_LEN) the block
// produces one result per slot written, carrying the slot index and the
// current cycle bit, plus one link result (is_link=1, owner_tag 0) whenever the
// write index stands on the link slot, after which the index wraps to 0 and the
// cycle bit flips. Otherwise a single ring-full result comes back. A zero
// length insert returns one ok result and changes nothing. A completion
// transfer gives an entry address; slot = (entry_addr - ring_base) >> 4, and
// the owner recorded for that slot releases its length from the pending count.
// Completion with nothing pending or a slot past the usable range returns
// status 2. Completing a slot that was never written returns undefined tag.
// The last result of every input has last=1. Ring size is clamped to
// 2..RING_MAX. An insert goes through S_CHECK and then S_INSERT, where the write
// loop feeds the single result register one slot per cycle while the output is
// not stalled, plus a link result at the link slot; a completion reads the owner
// memory (registered read) ahead of S_COMPLETE. A new input is taken as soon as
// the previous one has placed its last result in the output register, so the
// next item can be accepted while that result still waits for out_ready.
// Configuration writes must only be issued while the block is idle.
module transfer_ring_producer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  trp_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output trp_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import trp_pkg::*;

  // Control and configuration state
  state_t            state, state_next;
  logic [IDX_W-1:0]  size_m1;      // usable slots = index of the link slot
  logic [ADDR_W-1:0] ring_base;
  logic [IDX_W-1:0]  write_index, write_index_next;
  logic              cycle_state, cycle_state_next;
  logic [IDX_W-1:0]  pending_count, pending_count_next;
  logic [LEN_W-1:0]  done_count, done_count_next;

  // Held input item and completion slot
  in_item_t          item;
  logic [IDX_W-1:0]  cmp_slot, cmp_slot_next;

  // Owner memory, one entry per slot, registered read
  owner_t            slot_owner [RING_MAX];
  owner_t            owner_rdata;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  owner_t            mem_wdata;

  // Result register
  logic              emit;
  out_item_t         result;
  logic              can_emit;

  // Combinational helpers
  logic [IDX_W:0]        need;
  logic                  full;
  logic [ADDR_W-1:0]     diff;
  logic                  bad_slot;
  logic [IDX_W-1:0]      olen;
  logic [SLOTS_W-1:0]    slots_wr;

  assign can_emit = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  assign need = {1'b0, pending_count} + (IDX_W+1)'(item.req_len);
  assign full = (32'(item.req_len) > 32'(MAX_REQ_LEN)) || (need > {1'b0, size_m1});

  assign diff     = item.entry_addr - ring_base;
  assign bad_slot = (|diff[ADDR_W-1:ENTRY_SHIFT+IDX_W])
                    || (diff[ENTRY_SHIFT+IDX_W-1:ENTRY_SHIFT] >= size_m1);
  assign olen     = IDX_W'(owner_rdata.len);
  assign slots_wr = cfg_data[SLOTS_W-1:0];

  // Configuration registers; size is clamped when written
  always_ff @(posedge clk) begin
    if (rst) begin
      size_m1   <= IDX_W'(RING_MAX - 1);
      ring_base <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RING_SLOTS: begin
          if (slots_wr < SLOTS_W'(2)) begin
            size_m1 <= IDX_W'(1);
          end else if (32'(slots_wr) > 32'(RING_MAX)) begin
            size_m1 <= IDX_W'(RING_MAX - 1);
          end else begin
            size_m1 <= IDX_W'(slots_wr - SLOTS_W'(1));
          end
        end
        REG_RING_BASE: ring_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_index   <= '0;
      cycle_state   <= 1'b1;
      pending_count <= '0;
      done_count    <= '0;
    end else begin
      state         <= state_next;
      write_index   <= write_index_next;
      cycle_state   <= cycle_state_next;
      pending_count <= pending_count_next;
      done_count    <= done_count_next;
    end
  end

  // Payload holding registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
    cmp_slot <= cmp_slot_next;
  end

  // Owner memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_owner[write_index] <= mem_wdata;
    end
    if (mem_re) begin
      owner_rdata <= slot_owner[mem_raddr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= result;
    end
  end

  // Next state and outputs
  always_comb begin
    state_next         = state;
    write_index_next   = write_index;
    cycle_state_next   = cycle_state;
    pending_count_next = pending_count;
    done_count_next    = done_count;
    cmp_slot_next      = cmp_slot;
    emit               = 1'b0;
    result             = '0;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    mem_raddr          = diff[ENTRY_SHIFT+IDX_W-1:ENTRY_SHIFT];
    mem_wdata          = '{len: item.req_len, tag: item.req_tag};

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        if (item.op == OP_INSERT) begin
          if (full || item.req_len == '0) begin
            // ring full or zero length: one result, nothing changes
            if (can_emit) begin
              emit               = 1'b1;
              result.status      = full ? STATUS_FULL : STATUS_OK;
              result.slot_index  = 8'(write_index);
              result.cycle_value = cycle_state;
              result.owner_tag   = item.req_tag;
              result.last        = 1'b1;
              state_next         = S_IDLE;
            end
          end else begin
            pending_count_next = need[IDX_W-1:0];
            done_count_next    = '0;
            state_next         = S_INSERT;
          end
        end else begin
          if (pending_count == '0 || bad_slot) begin
            if (can_emit) begin
              emit          = 1'b1;
              result.status = STATUS_NO_PEND;
              result.last   = 1'b1;
              state_next    = S_IDLE;
            end
          end else begin
            mem_re        = 1'b1;
            cmp_slot_next = mem_raddr;
            state_next    = S_COMPLETE;
          end
        end
      end

      S_INSERT: begin
        if (can_emit) begin
          emit               = 1'b1;
          result.status      = STATUS_OK;
          result.slot_index  = 8'(write_index);
          result.cycle_value = cycle_state;
          if (write_index >= size_m1) begin
            // link slot: wrap and flip the cycle bit
            result.is_link   = 1'b1;
            write_index_next = '0;
            cycle_state_next = !cycle_state;
          end else begin
            result.owner_tag = item.req_tag;
            mem_we           = 1'b1;
            write_index_next = write_index + IDX_W'(1);
            done_count_next  = done_count + LEN_W'(1);
            if (LEN_W'(done_count + LEN_W'(1)) == item.req_len) begin
              result.last = 1'b1;
              state_next  = S_IDLE;
            end
          end
        end
      end

      S_COMPLETE: begin
        if (can_emit) begin
          emit              = 1'b1;
          result.status     = STATUS_OK;
          result.slot_index = 8'(cmp_slot);
          result.owner_tag  = owner_rdata.tag;
          result.last       = 1'b1;
          pending_count_next = (olen > pending_count) ? '0 : pending_count - olen;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/trp_checker.sv */
// Port-level checker for the transfer ring producer, with its bind.
module trp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input trp_pkg::out_item_t  out_item
);
  import trp_pkg::*;

  // items accepted whose last result has not yet transferred
  logic [1:0] open_items;
  logic       in_xfer, out_last_xfer;

  assign in_xfer       = in_valid && in_ready;
  assign out_last_xfer = out_valid && out_ready && out_item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_items <= '0;
    end else begin
      open_items <= open_items + 2'(in_xfer) - 2'(out_last_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_one_ahead: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> open_items < 2'd2)
    else $error("input taken with two items open");

  a_out_owned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> open_items != 2'd0)
    else $error("result with no open item");

  a_link_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_link |->
      out_item.status == STATUS_OK && out_item.owner_tag == '0 && !out_item.last)
    else $error("malformed link result");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != STATUS_OK |-> out_item.last && !out_item.is_link)
    else $error("error result not final");

endmodule

bind transfer_ring_producer trp_checker u_trp_checker (.*);

/* tb/transfer_ring_producer_tb.sv */
// Testbench for the transfer ring producer: directed table, then randomized phases.
`timescale 1ns / 100ps

module transfer_ring_producer_tb;
  import trp_pkg::*;

  localparam int ITEMS_PER_PHASE = 41;
  localparam int NUM_PHASES      = 8;
  localparam int DRAIN_CYCLES    = 12;   // covers the longest insert path, link slot included
  localparam int HEAVY_PCT       = 73;
  localparam int LIGHT_PCT       = 12;

  // One row of the directed table: either a register write or an input transfer,
  // optionally with the single result it must produce typed in.
  typedef struct {
    bit          is_cfg;
    logic [0:0]  cfg_reg;
    logic [63:0] cfg_value;
    in_item_t    item;
    bit          typed;
    out_item_t   exp;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;

  // Shadow copy of the ring state, advanced once per accepted input transfer.
  logic [8:0]  ring_slots_cfg = 9'd256;
  logic [63:0] ring_base_cfg  = '0;
  logic [7:0]  wr_idx         = '0;
  logic        cycle_bit      = 1'b1;
  int          pending        = 0;
  logic [7:0]  slot_tag     [RING_MAX];
  logic [3:0]  slot_len     [RING_MAX];
  bit          slot_written [RING_MAX];

  int          open_slots[$];      // first slot of each inserted request, oldest first
  out_item_t   ring_results_q[$];  // expected results, oldest first
  stim_row_t   stim_table[$];

  transfer_ring_producer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective ring size: register value clamped to 2..RING_MAX.
  function automatic int ring_size();
    int s;
    s = ring_slots_cfg;
    if (s < 2) s = 2;
    if (s > RING_MAX) s = RING_MAX;
    return s;
  endfunction

  function automatic void add_result(logic [1:0] status, logic [7:0] slot, logic cyc,
                                     logic link, logic [7:0] tag);
    out_item_t r;
    r.status      = status;
    r.slot_index  = slot;
    r.cycle_value = cyc;
    r.is_link     = link;
    r.owner_tag   = tag;
    r.last        = 1'b0;
    ring_results_q.push_back(r);
  endfunction

  // Advance the shadow ring by one input and queue the results it causes.
  // Returns how many results were queued.
  function automatic int compute_ring_results(in_item_t it);
    int          size;
    int          len;
    int          done;
    int          n;
    logic [63:0] slot;
    out_item_t   tail;
    size = ring_size();
    len  = it.req_len;
    n    = 0;
    if (it.op == OP_INSERT) begin
      if (len > MAX_REQ_LEN || pending + len > size - 1) begin
        add_result(STATUS_FULL, wr_idx, cycle_bit, 1'b0, it.req_tag);
        n = 1;
      end else if (len == 0) begin
        add_result(STATUS_OK, wr_idx, cycle_bit, 1'b0, it.req_tag);
        n = 1;
      end else begin
        pending += len;
        done = 0;
        while (done < len) begin
          if (int'(wr_idx) + 1 >= size) begin
            // On or past the link slot (a shrink can leave the index beyond it)
            add_result(STATUS_OK, wr_idx, cycle_bit, 1'b1, '0);
            wr_idx    = '0;
            cycle_bit = ~cycle_bit;
          end else begin
            if (done == 0) open_slots.push_back(int'(wr_idx));
            add_result(STATUS_OK, wr_idx, cycle_bit, 1'b0, it.req_tag);
            slot_tag[wr_idx]     = it.req_tag;
            slot_len[wr_idx]     = 4'(len);
            slot_written[wr_idx] = 1'b1;
            wr_idx++;
            done++;
          end
          n++;
        end
      end
    end else begin
      slot = (it.entry_addr - ring_base_cfg) >> ENTRY_SHIFT;
      if (pending == 0 || slot >= 64'(size - 1)) begin
        add_result(STATUS_NO_PEND, '0, 1'b0, 1'b0, '0);
      end else begin
        // release the owner's length, never below zero
        pending = (int'(slot_len[slot[7:0]]) > pending) ? 0
                                                        : pending - slot_len[slot[7:0]];
        add_result(STATUS_OK, slot[7:0], 1'b0, 1'b0, slot_tag[slot[7:0]]);
      end
      n = 1;
    end
    tail      = ring_results_q.pop_back();
    tail.last = 1'b1;
    ring_results_q.push_back(tail);
    return n;
  endfunction

  // Random input: mostly well-formed inserts and completions of live requests,
  // the rest bad lengths and stray addresses.
  function automatic in_item_t make_random_item();
    in_item_t    it;
    int          size;
    int          pick;
    int          lim;
    int          slot;
    logic [63:0] idx;
    size = ring_size();
    lim  = (size - 1 < MAX_REQ_LEN) ? size - 1 : MAX_REQ_LEN;
    pick = $urandom_range(0, 99);
    it.op         = OP_INSERT;
    it.req_tag    = 8'($urandom);
    it.req_len    = 4'($urandom_range(1, lim));
    it.entry_addr = {$urandom, $urandom};
    if (pick >= 45 && pick < 52) begin
      it.req_len = 4'($urandom_range(0, 15));
    end else if (pick >= 52) begin
      it.op      = OP_COMPLETE;
      it.req_len = 4'($urandom_range(0, 15));
      if (pick < 92) begin
        slot = -1;
        while (slot < 0 && open_slots.size() != 0) begin
          slot = open_slots.pop_front();
          if (slot >= size - 1 || !slot_written[slot]) slot = -1;
        end
        if (slot >= 0)
          it.entry_addr = ring_base_cfg + (64'(slot) << ENTRY_SHIFT)
                          + 64'($urandom_range(0, 15));
      end
      // never look up a slot whose owner was never recorded
      idx = (it.entry_addr - ring_base_cfg) >> ENTRY_SHIFT;
      if (pending != 0 && idx < 64'(size - 1) && !slot_written[idx[7:0]])
        it.entry_addr = ring_base_cfg + (64'(size - 1) << ENTRY_SHIFT);
    end
    return it;
  endfunction

  function automatic stim_row_t item_row(op_t op, logic [7:0] tag, logic [3:0] len,
                                         logic [63:0] addr);
    stim_row_t r;
    r.is_cfg          = 1'b0;
    r.cfg_reg         = '0;
    r.cfg_value       = '0;
    r.item.op         = op;
    r.item.req_tag    = tag;
    r.item.req_len    = len;
    r.item.entry_addr = addr;
    r.typed           = 1'b0;
    r.exp             = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(op_t op, logic [7:0] tag, logic [3:0] len,
                                          logic [63:0] addr, logic [1:0] status,
                                          logic [7:0] slot, logic cyc, logic [7:0] exp_tag);
    stim_row_t r;
    r       = item_row(op, tag, len, addr);
    r.typed = 1'b1;
    r.exp   = '{status: status, slot_index: slot, cycle_value: cyc, is_link: 1'b0,
                owner_tag: exp_tag, last: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [0:0] reg_sel, logic [63:0] value);
    stim_row_t r;
    r           = item_row(OP_INSERT, '0, '0, '0);
    r.is_cfg    = 1'b1;
    r.cfg_reg   = reg_sel;
    r.cfg_value = value;
    return r;
  endfunction

  // Offer one input transfer and hold it until accepted. Acceptance is seen at
  // the falling edge before the rising edge that takes it.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t exp);
    int n;
    bit hit;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    hit = 1'b0;
    while (!hit) begin
      @(negedge clk);
      hit = in_ready;
    end
    n = compute_ring_results(it);
    if (typed) begin
      // directed rows with a typed-in answer replace the predicted result
      repeat (n) void'(ring_results_q.pop_back());
      ring_results_q.push_back(exp);
    end
    @(posedge clk);
  endtask

  // Block is idle once every expected result is out, plus the DRAIN_CYCLES margin.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (ring_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] reg_sel, input logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_sel == REG_RING_SLOTS) ring_slots_cfg = value[8:0];
    else ring_base_cfg = value;
  endtask

  // Receiver back-pressure
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Result checker: a transfer is seen at the falling edge ahead of the edge
  // that completes it, so samples never race the drivers.
  always @(negedge clk) begin
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (ring_results_q.size() == 0) begin
        $error("unexpected result transfer: %p", out_item);
        mismatches++;
      end else begin
        want = ring_results_q.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatches++;
        end
        if (out_item.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_item.slot_index);
          mismatches++;
        end
        if (out_item.cycle_value !== want.cycle_value) begin
          $error("cycle_value: expected %0d, got %0d", want.cycle_value,
                 out_item.cycle_value);
          mismatches++;
        end
        if (out_item.is_link !== want.is_link) begin
          $error("is_link: expected %0d, got %0d", want.is_link, out_item.is_link);
          mismatches++;
        end
        if (out_item.owner_tag !== want.owner_tag) begin
          $error("owner_tag: expected %0d, got %0d", want.owner_tag, out_item.owner_tag);
          mismatches++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t   row;
    logic [8:0]  slots;
    logic [63:0] base;

    // Directed table. Comments track the shadow state after each row.
    // After reset: size 256, base 0, index 0, cycle 1, nothing pending.
    stim_table.push_back(typed_row(OP_COMPLETE, 8'h00, 4'd0, 64'h0,
                                   STATUS_NO_PEND, 8'd0, 1'b0, 8'h00));
    stim_table.push_back(typed_row(OP_INSERT, 8'h5A, 4'd0, '1,
                                   STATUS_OK, 8'd0, 1'b1, 8'h5A));   // zero length
    stim_table.push_back(typed_row(OP_INSERT, 8'hFF, 4'd9, 64'h0,
                                   STATUS_FULL, 8'd0, 1'b1, 8'hFF)); // too long
    stim_table.push_back(typed_row(OP_INSERT, 8'h00, 4'd15, 64'h0,
                                   STATUS_FULL, 8'd0, 1'b1, 8'h00));
    stim_table.push_back(item_row(OP_INSERT, 8'h11, 4'd8, 64'h0));   // slots 0..7
    stim_table.push_back(item_row(OP_INSERT, 8'hFF, 4'd1, '1));      // slot 8
    stim_table.push_back(item_row(OP_COMPLETE, 8'h00, 4'd0, 64'hF)); // low bits ignored
    stim_table.push_back(typed_row(OP_COMPLETE, 8'hFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFF0,
                                   STATUS_NO_PEND, 8'd0, 1'b0, 8'h00)); // slot out of range
    stim_table.push_back(item_row(OP_COMPLETE, 8'h00, 4'd0, 64'h80)); // pending back to 0
    // Smallest ring with the write index left beyond the link slot
    stim_table.push_back(cfg_row(REG_RING_SLOTS, 64'd2));
    stim_table.push_back(cfg_row(REG_RING_BASE, 64'hFFFF_FFFF_FFFF_FFF0));
    stim_table.push_back(item_row(OP_INSERT, 8'h22, 4'd1, 64'h0));   // link, then slot 0
    stim_table.push_back(item_row(OP_INSERT, 8'h33, 4'd1, 64'h0));   // full
    stim_table.push_back(item_row(OP_COMPLETE, 8'h00, 4'd0, 64'hFFFF_FFFF_FFFF_FFF5));
    stim_table.push_back(item_row(OP_INSERT, 8'h44, 4'd1, 64'h0));   // link again
    stim_table.push_back(cfg_row(REG_RING_SLOTS, 64'd0));            // clamps to 2
    stim_table.push_back(typed_row(OP_COMPLETE, 8'h00, 4'd0, 64'h0,
                                   STATUS_NO_PEND, 8'd0, 1'b0, 8'h00)); // address wraps
    stim_table.push_back(cfg_row(REG_RING_SLOTS, 64'd1));
    stim_table.push_back(item_row(OP_INSERT, 8'h55, 4'd1, 64'h0));   // full
    // Oversized register clamps to RING_MAX
    stim_table.push_back(cfg_row(REG_RING_SLOTS, 64'd511));
    stim_table.push_back(cfg_row(REG_RING_BASE, 64'h1000));
    stim_table.push_back(item_row(OP_INSERT, 8'hAA, 4'd8, 64'h0));   // slots 1..8
    stim_table.push_back(item_row(OP_COMPLETE, 8'h00, 4'd0, 64'h1030));
    stim_table.push_back(item_row(OP_COMPLETE, 8'h00, 4'd0, 64'h1040)); // saturates at 0
    stim_table.push_back(typed_row(OP_COMPLETE, 8'h00, 4'd0, 64'h1010,
                                   STATUS_NO_PEND, 8'd0, 1'b0, 8'h00));
    stim_table.push_back(item_row(OP_INSERT, 8'h80, 4'd8, 64'h0));   // slots 9..16
    // Shrink below the write index: next write lands on the link slot
    stim_table.push_back(cfg_row(REG_RING_SLOTS, 64'd10));
    stim_table.push_back(item_row(OP_COMPLETE, 8'h00, 4'd0, 64'h1090));
    stim_table.push_back(item_row(OP_INSERT, 8'h01, 4'd8, 64'h0));
    stim_table.push_back(item_row(OP_INSERT, 8'h02, 4'd2, 64'h0));   // full
    stim_table.push_back(item_row(OP_COMPLETE, 8'h00, 4'd0, 64'h108F));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.cfg_reg, row.cfg_value);
      end else begin
        send_item(row.item, row.typed, row.exp);
      end
    end

    // Random phases: each one reprograms the ring, then runs one idling mode
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin slots = 9'd256; base = '0; end
        1: begin slots = 9'd2; base = '1; end
        2: begin slots = 9'd511; base = {$urandom, $urandom} & ~64'hF; end
        3: begin slots = 9'($urandom_range(3, 40)); base = {$urandom, $urandom}; end
        4: begin slots = 9'd1; base = {$urandom, $urandom}; end
        5: begin slots = 9'($urandom_range(2, 256)); base = {$urandom, $urandom}; end
        6: begin slots = 9'($urandom_range(257, 511)); base = {$urandom, $urandom}; end
        default: begin slots = 9'($urandom_range(4, 16)); base = {$urandom, $urandom}; end
      endcase
      wait_idle();
      write_reg(REG_RING_SLOTS, {55'd0, slots});
      write_reg(REG_RING_BASE, base);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = HEAVY_PCT; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = HEAVY_PCT; end
        default: begin send_idle_pct = LIGHT_PCT; recv_stall_pct = LIGHT_PCT; end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 1 && k == ITEMS_PER_PHASE / 2) begin
          // sender holds off until everything in flight has come back
          in_valid <= 1'b0;
          do @(posedge clk); while (ring_results_q.size() != 0);
        end
        send_item(make_random_item(), 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
